FILE: hdl/cdas_pkg.sv
// ----------------------------------------------------------------------------
// cdas_pkg
// Shared constants and small lookup functions for the date/time advance block.
// ----------------------------------------------------------------------------
package cdas_pkg;

  localparam int unsigned EpochYear  = 2000;
  localparam int unsigned SecsPerDay = 86400;

  // Day 0 is Saturday; (day + 5) mod 7 + 1 gives Monday = 1.
  localparam int unsigned WeekdayBias = 5;

  // First day after the skipped February 29 of 2100, counted from the epoch.
  localparam int unsigned Skip2100Day = 36584;
  // Offset from the epoch to a March 1 that starts a four-year leap cycle.
  localparam int unsigned MarchShift  = 1401;
  localparam int unsigned CycleBase   = 1996;

  // Reciprocals for division by constants, each checked over its input range.
  localparam int unsigned RecipDiv25   = 1311;      // >> 15, x < 1024
  localparam int unsigned RecipDiv675  = 50903317;  // >> 35, x < 2**25
  localparam int unsigned RecipDiv1461 = 45934;     // >> 26, x < 2**16
  localparam int unsigned RecipDiv7    = 74899;     // >> 19, x < 2**16
  localparam int unsigned RecipDiv60a  = 139811;    // >> 23, x < 2**17
  localparam int unsigned RecipDiv60b  = 2185;      // >> 17, x < 1440
  localparam int unsigned RecipDiv153  = 1714;      // >> 18, x < 1828

  // Month term of the day formula, 367 * mm / 12 with mm = 1 for March.
  function automatic logic [8:0] month_offset(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd0:    r = 9'd305;
      4'd1:    r = 9'd336;
      4'd2:    r = 9'd367;
      4'd3:    r = 9'd30;
      4'd4:    r = 9'd61;
      4'd5:    r = 9'd91;
      4'd6:    r = 9'd122;
      4'd7:    r = 9'd152;
      4'd8:    r = 9'd183;
      4'd9:    r = 9'd214;
      4'd10:   r = 9'd244;
      4'd11:   r = 9'd275;
      4'd12:   r = 9'd305;
      4'd13:   r = 9'd336;
      4'd14:   r = 9'd367;
      default: r = 9'd397;
    endcase
    return r;
  endfunction

  // First day-of-year of each March-based month, (153 * mp + 2) / 5.
  function automatic logic [8:0] march_month_start(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/cdas_date_to_days.sv
// ----------------------------------------------------------------------------
// cdas_date_to_days
// Converts a calendar date to whole days since the epoch, saturating at zero.
// ----------------------------------------------------------------------------
module cdas_date_to_days (
  input  logic [11:0] year_i,
  input  logic [3:0]  month_i,
  input  logic [4:0]  day_i,
  output logic [19:0] days_o
);
  import cdas_pkg::*;

  logic        clamp;
  logic [11:0] y_c;
  logic [3:0]  m_c;
  logic [11:0] y_s;
  logic [20:0] p100;
  logic [20:0] p400;
  logic [5:0]  c100;
  logic [5:0]  c400;
  logic [11:0] k;
  logic [20:0] k365;
  logic [20:0] pos;
  logic [20:0] neg;

  always_comb begin
    clamp = (year_i < 12'(EpochYear));
    y_c   = clamp ? 12'(EpochYear) : year_i;
    m_c   = clamp ? 4'd1 : month_i;
    // January and February belong to the previous March-based year.
    y_s   = y_c - {11'd0, (m_c <= 4'd2)};
    p100  = {11'd0, y_s[11:2]} * 21'(RecipDiv25);
    p400  = {13'd0, y_s[11:4]} * 21'(RecipDiv25);
    c100  = p100[20:15];
    c400  = p400[20:15];
    k     = y_s - 12'(EpochYear - 1);
    k365  = {9'd0, k} * 21'd365;
    pos   = k365 + {11'd0, y_s[11:2]} + {15'd0, c400}
          + {12'd0, month_offset(m_c)} + {16'd0, day_i};
    // The date's century term, plus the leap and month/day terms of the epoch day.
    neg   = {15'd0, c100} + 21'd821;
    days_o = (pos >= neg) ? 20'(pos - neg) : 20'd0;
  end

endmodule

FILE: hdl/calendar_datetime_add_seconds.sv
// ----------------------------------------------------------------------------
// calendar_datetime_add_seconds
// Advances a Gregorian date and time by a number of seconds.
// ----------------------------------------------------------------------------
// A new item may be started in every clock cycle; busy is always low. Each
// item's result appears on the result ports with result_valid_o high, one
// result per item, in order, after passing through the seven register stages
// of the pipeline (day count, total seconds, division by 86400, four-year
// cycle split, time split, month split, output).
// The receiver cannot stall the block, so nothing ever holds back an item.
module calendar_datetime_add_seconds (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] year_i,
  input  logic [3:0]  month_i,
  input  logic [4:0]  day_of_month_i,
  input  logic [4:0]  hour_i,
  input  logic [5:0]  minute_i,
  input  logic [5:0]  second_i,
  input  logic [31:0] add_seconds_i,
  output logic        result_valid_o,
  output logic [11:0] out_year_o,
  output logic [3:0]  out_month_o,
  output logic [4:0]  out_day_o,
  output logic [4:0]  out_hour_o,
  output logic [5:0]  out_minute_o,
  output logic [5:0]  out_second_o,
  output logic [2:0]  weekday_o,
  output logic [15:0] day_count_o
);
  import cdas_pkg::*;

  logic [6:0] vld_q;

  // Stage 1
  logic [19:0] days_d, days_q;
  logic [31:0] addt_d, addt_q;
  // Stage 2
  logic [36:0] dsec;
  logic [31:0] total_d, total2_q;
  // Stage 3
  logic [50:0] qprod;
  logic [15:0] dc_d, dc3_q;
  logic [31:0] total3_q;
  // Stage 4
  logic [32:0] dcsec;
  logic [16:0] tod_d, tod4_q;
  logic [15:0] dcp, z_d, z4_q;
  logic [31:0] cprod;
  logic [5:0]  cyc_d, cyc4_q;
  logic [16:0] wx4;
  logic [33:0] wprod;
  logic [13:0] wq_d, wq4_q;
  logic [15:0] dc4_q;
  // Stage 5
  logic [15:0] r16;
  logic [10:0] r;
  logic [1:0]  yoe_d, yoe5_q;
  logic [8:0]  doy_d, doy5_q;
  logic [34:0] tprod;
  logic [10:0] q1_d, q1_5_q;
  logic [16:0] wx5;
  logic [16:0] w7;
  logic [2:0]  wd_d, wd5_q, wd6_q;
  logic [16:0] tod5_q;
  logic [5:0]  cyc5_q, cyc6_q;
  logic [15:0] dc5_q, dc6_q;
  // Stage 6
  logic [10:0] mx;
  logic [21:0] mprod;
  logic [3:0]  mp_d, mp6_q;
  logic [16:0] s60;
  logic [5:0]  sec_d, sec6_q;
  logic [22:0] hprod;
  logic [4:0]  hr_d, hr6_q;
  logic [8:0]  doy6_q;
  logic [1:0]  yoe6_q;
  logic [10:0] q1_6_q;
  // Stage 7
  logic [8:0]  dday;
  logic [10:0] m60;
  logic [11:0] yr;

  assign busy = 1'b0;

  cdas_date_to_days u_d2d (
    .year_i  (year_i),
    .month_i (month_i),
    .day_i   (day_of_month_i),
    .days_o  (days_d)
  );

  always_comb begin
    addt_d  = add_seconds_i + 32'({5'd0, hour_i} * 17'd3600)
            + 32'({6'd0, minute_i} * 12'd60) + {26'd0, second_i};

    dsec    = {17'd0, days_q} * 37'(SecsPerDay);
    total_d = dsec[31:0] + addt_q;

    // total / 86400 = (total >> 7) / 675.
    qprod   = {26'd0, total2_q[31:7]} * 51'(RecipDiv675);
    dc_d    = qprod[50:35];

    dcsec   = {17'd0, dc3_q} * 33'(SecsPerDay);
    tod_d   = total3_q[16:0] - dcsec[16:0];
    // Treat 2100 as leap in a uniform four-year calendar by skipping its Feb 29.
    dcp     = dc3_q + {15'd0, (dc3_q >= 16'(Skip2100Day))};
    z_d     = dcp + 16'(MarchShift);
    cprod   = {16'd0, z_d} * 32'(RecipDiv1461);
    cyc_d   = cprod[31:26];
    wx4     = {1'b0, dc3_q} + 17'(WeekdayBias);
    wprod   = {17'd0, wx4} * 34'(RecipDiv7);
    wq_d    = wprod[32:19];

    r16     = z4_q - 16'({10'd0, cyc4_q} * 16'd1461);
    r       = r16[10:0];
    if (r >= 11'd1095) begin
      yoe_d = 2'd3;
    end else if (r >= 11'd730) begin
      yoe_d = 2'd2;
    end else if (r >= 11'd365) begin
      yoe_d = 2'd1;
    end else begin
      yoe_d = 2'd0;
    end
    doy_d   = 9'(r - 11'({9'd0, yoe_d} * 11'd365));
    tprod   = {18'd0, tod4_q} * 35'(RecipDiv60a);
    q1_d    = tprod[33:23];
    wx5     = {1'b0, dc4_q} + 17'(WeekdayBias);
    w7      = wx5 - 17'({3'd0, wq4_q} * 17'd7);
    wd_d    = w7[2:0] + 3'd1;

    mx      = 11'({2'd0, doy5_q} * 11'd5) + 11'd2;
    mprod   = {11'd0, mx} * 22'(RecipDiv153);
    mp_d    = mprod[21:18];
    s60     = tod5_q - 17'({6'd0, q1_5_q} * 17'd60);
    sec_d   = s60[5:0];
    hprod   = {12'd0, q1_5_q} * 23'(RecipDiv60b);
    hr_d    = hprod[21:17];

    dday    = doy6_q - march_month_start(mp6_q) + 9'd1;
    m60     = q1_6_q - 11'({6'd0, hr6_q} * 11'd60);
    yr      = 12'(CycleBase) + {4'd0, cyc6_q, 2'd0} + {10'd0, yoe6_q}
            + {11'd0, (mp6_q >= 4'd10)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[5:0], start};
    end
  end

  always_ff @(posedge clk_i) begin
    days_q   <= days_d;
    addt_q   <= addt_d;
    total2_q <= total_d;
    dc3_q    <= dc_d;
    total3_q <= total2_q;
    tod4_q   <= tod_d;
    z4_q     <= z_d;
    cyc4_q   <= cyc_d;
    wq4_q    <= wq_d;
    dc4_q    <= dc3_q;
    yoe5_q   <= yoe_d;
    doy5_q   <= doy_d;
    q1_5_q   <= q1_d;
    wd5_q    <= wd_d;
    tod5_q   <= tod4_q;
    cyc5_q   <= cyc4_q;
    dc5_q    <= dc4_q;
    mp6_q    <= mp_d;
    sec6_q   <= sec_d;
    hr6_q    <= hr_d;
    doy6_q   <= doy5_q;
    yoe6_q   <= yoe5_q;
    q1_6_q   <= q1_5_q;
    wd6_q    <= wd5_q;
    cyc6_q   <= cyc5_q;
    dc6_q    <= dc5_q;
    out_year_o   <= yr;
    out_month_o  <= (mp6_q < 4'd10) ? mp6_q + 4'd3 : mp6_q - 4'd9;
    out_day_o    <= dday[4:0];
    out_hour_o   <= hr6_q;
    out_minute_o <= m60[5:0];
    out_second_o <= sec6_q;
    weekday_o    <= wd6_q;
    day_count_o  <= dc6_q;
  end

  assign result_valid_o = vld_q[6];

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives date/time items with random offsets into the date/time advance block
// and compares every result against an independent calendar predictor.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [31:0] add;
  } stamp_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
    logic [15:0] day_count;
  } civil_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [11:0] year_i;
  logic [3:0]  month_i;
  logic [4:0]  day_of_month_i;
  logic [4:0]  hour_i;
  logic [5:0]  minute_i;
  logic [5:0]  second_i;
  logic [31:0] add_seconds_i;
  logic        result_valid_o;
  logic [11:0] out_year_o;
  logic [3:0]  out_month_o;
  logic [4:0]  out_day_o;
  logic [4:0]  out_hour_o;
  logic [5:0]  out_minute_o;
  logic [5:0]  out_second_o;
  logic [2:0]  weekday_o;
  logic [15:0] day_count_o;

  stamp_t pending_stamps[$];
  civil_t expected_dates[$];
  int     mismatches = 0;
  bit     stimulus_done = 0;
  int     cycle_no = 0;

  calendar_datetime_add_seconds dut (.*);

  function automatic bit leap_year(int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  // Absolute day number with March-based months, so the leap day falls last.
  function automatic int unsigned day_number(int unsigned y, int unsigned m, int unsigned d);
    int mm;
    mm = int'(m) - 2;
    if (mm <= 0) begin
      mm += 12;
      y -= 1;
    end
    return y / 4 - y / 100 + y / 400 + int'(367 * mm / 12) + d + y * 365;
  endfunction

  function automatic civil_t advance_date(stamp_t s);
    civil_t r;
    int unsigned y, m, origin, a, days, ylen, mlen, rest, mo, yr, tod;
    logic [31:0] total, dc;
    y = 32'(s.year);
    m = 32'(s.month);
    origin = day_number(cdas_pkg::EpochYear, 1, 1);
    if (y < cdas_pkg::EpochYear) begin
      y = cdas_pkg::EpochYear;
      m = 1;
    end
    a = day_number(y, m, 32'(s.day));
    days = (a >= origin) ? a - origin : 0;
    total = days * 32'd86400;
    total = total + 32'(s.second) + 32'(s.minute) * 32'd60 + 32'(s.hour) * 32'd3600;
    total = total + s.add;
    dc = total / 32'd86400;
    tod = total % 32'd86400;
    rest = dc;
    yr = cdas_pkg::EpochYear;
    forever begin
      ylen = leap_year(yr) ? 366 : 365;
      if (rest < ylen) break;
      rest -= ylen;
      yr++;
    end
    mo = 0;
    forever begin
      if (mo >= 11) break;
      case (mo)
        1: mlen = leap_year(yr) ? 29 : 28;
        3, 5, 8, 10: mlen = 30;
        default: mlen = 31;
      endcase
      if (rest < mlen) break;
      rest -= mlen;
      mo++;
    end
    r.year = 12'(yr);
    r.month = 4'(mo + 1);
    r.day = 5'(rest + 1);
    r.hour = 5'(tod / 3600);
    r.minute = 6'((tod / 60) % 60);
    r.second = 6'(tod % 60);
    r.weekday = 3'(((dc + origin + 6) % 7) + 1);
    r.day_count = dc[15:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_no);
    mismatches++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_no <= cycle_no + 1;

  // Idles with a chance of 12 percent, except in a quiet window with no gaps.
  function automatic bit take_gap();
    if (cycle_no > 400 && cycle_no < 900) return 1'b0;
    return $urandom_range(99) < 12;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    stamp_t s;
    if (!rst_ni) begin
      start <= 1'b0;
      {year_i, month_i, day_of_month_i, hour_i, minute_i, second_i, add_seconds_i} <= '0;
    end else begin
      if (start && !busy) expected_dates.push_back(advance_date({year_i, month_i,
          day_of_month_i, hour_i, minute_i, second_i, add_seconds_i}));
      if ((!start || !busy) && pending_stamps.size() > 0 && !take_gap()) begin
        s = pending_stamps.pop_front();
        start <= 1'b1;
        year_i <= s.year;
        month_i <= s.month;
        day_of_month_i <= s.day;
        hour_i <= s.hour;
        minute_i <= s.minute;
        second_i <= s.second;
        add_seconds_i <= s.add;
      end else if (!start || !busy) begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    civil_t w;
    if (rst_ni && result_valid_o) begin
      if (expected_dates.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        w = expected_dates.pop_front();
        if (out_year_o !== w.year)
          report_mismatch("year", int'(out_year_o), int'(w.year));
        if (out_month_o !== w.month)
          report_mismatch("month", int'(out_month_o), int'(w.month));
        if (out_day_o !== w.day)
          report_mismatch("day", int'(out_day_o), int'(w.day));
        if (out_hour_o !== w.hour)
          report_mismatch("hour", int'(out_hour_o), int'(w.hour));
        if (out_minute_o !== w.minute)
          report_mismatch("minute", int'(out_minute_o), int'(w.minute));
        if (out_second_o !== w.second)
          report_mismatch("second", int'(out_second_o), int'(w.second));
        if (weekday_o !== w.weekday)
          report_mismatch("weekday", int'(weekday_o), int'(w.weekday));
        if (day_count_o !== w.day_count)
          report_mismatch("day count", int'(day_count_o), int'(w.day_count));
      end
    end
  end

  task automatic queue_stamp(int y, int m, int d, int h, int mi, int s, logic [31:0] add);
    stamp_t t;
    t.year = 12'(y); t.month = 4'(m); t.day = 5'(d); t.hour = 5'(h);
    t.minute = 6'(mi); t.second = 6'(s);
    t.add = add;
    pending_stamps.push_back(t);
  endtask

  initial begin
    stamp_t t;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Extremes of the fields and the special cases: early years, month zero,
    // months past December, day zero, oversized times and wrapping offsets.
    queue_stamp(2000, 1, 1, 0, 0, 0, 0);
    queue_stamp(1900, 7, 15, 12, 30, 30, 0);
    queue_stamp(1999, 12, 31, 23, 59, 59, 1);
    queue_stamp(0, 0, 0, 0, 0, 0, 0);
    queue_stamp(2000, 0, 1, 0, 0, 0, 5);
    queue_stamp(2000, 1, 0, 0, 0, 0, 100);
    queue_stamp(2001, 13, 31, 31, 63, 63, 0);
    queue_stamp(2050, 15, 31, 0, 0, 0, 0);
    queue_stamp(2135, 12, 31, 23, 59, 59, 32'hFFFF_FFFF);
    queue_stamp(4095, 15, 31, 31, 63, 63, 32'hFFFF_FFFF);
    queue_stamp(2000, 2, 29, 0, 0, 0, 0);
    queue_stamp(2100, 2, 28, 23, 59, 59, 1);
    queue_stamp(2100, 3, 1, 0, 0, 0, 0);
    queue_stamp(2004, 12, 31, 0, 0, 0, 86399);
    queue_stamp(2000, 1, 1, 0, 0, 0, 32'hFFFF_FFFF);
    queue_stamp(2000, 1, 1, 0, 0, 0, 32'h8000_0000);
    queue_stamp(2106, 2, 7, 6, 28, 15, 0);
    queue_stamp(2106, 2, 7, 6, 28, 16, 0);
    queue_stamp(2024, 6, 15, 12, 0, 0, 3600);
    for (int i = 0; i < 1550; i++) begin
      if ($urandom_range(9) < 8) begin
        t.year = 12'($urandom_range(2135, 1900));
        t.month = 4'($urandom_range(12, 1));
        t.day = 5'($urandom_range(31, 1));
        t.hour = 5'($urandom_range(23));
        t.minute = 6'($urandom_range(59));
        t.second = 6'($urandom_range(59));
      end else begin
        t.year = 12'($urandom);
        t.month = 4'($urandom);
        t.day = 5'($urandom);
        t.hour = 5'($urandom);
        t.minute = 6'($urandom);
        t.second = 6'($urandom);
      end
      case ($urandom_range(3))
        0: t.add = $urandom;
        1: t.add = $urandom_range(200000);
        2: t.add = 32'd0;
        default: t.add = 32'hFFFF_FFFF - $urandom_range(100000);
      endcase
      pending_stamps.push_back(t);
    end
    wait (pending_stamps.size() == 0);
    @(posedge clk_i);
    while (start) @(posedge clk_i);
    wait (expected_dates.size() == 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS calendar_datetime_add_seconds");
    end else begin
      $display("FAIL calendar_datetime_add_seconds");
    end
    $finish;
  end

  initial begin
    #500us;
    $display("FAIL calendar_datetime_add_seconds");
    $finish;
  end

endmodule
